### design/log_frequency_max_binning_scroll_macros.svh
// Assertion helpers for the top-level design file.
`ifndef LOG_FREQUENCY_MAX_BINNING_SCROLL_MACROS_SVH
`define LOG_FREQUENCY_MAX_BINNING_SCROLL_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define LFMBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfmbs: implication check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define LFMBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfmbs: next-cycle check failed");
`else
`define LFMBS_ASSERT_IMP(lbl, ante, cons)
`define LFMBS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/lfmbs_pkg.sv
package lfmbs_pkg;

  localparam logic [1:0] OP_SET_RANGE = 2'd0;
  localparam logic [1:0] OP_PUSH_BIN  = 2'd1;
  localparam logic [1:0] OP_READ_CELL = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  localparam logic [1:0] CFG_FLOOR = 2'd0;
  localparam logic [1:0] CFG_BINS  = 2'd1;

  localparam logic signed [15:0] FLOOR_RST = 16'sh8800;  // -120 dB
  localparam logic [10:0]        BINS_RST  = 11'd513;
  localparam logic [10:0]        CNT_SAT   = 11'd2047;

  // One command travelling down the row chain.
  typedef struct packed {
    logic               is_range;
    logic               is_bin;
    logic               last;
    logic               commit;
    logic [6:0]         row;
    logic [9:0]         lo;
    logic [9:0]         hi;
    logic [10:0]        idx;
    logic signed [15:0] value;
    logic signed [15:0] floor;
  } token_t;

  // Final row maximum draining toward the history write port.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] value;
  } lane_t;

endpackage

### design/lfmbs_cell.sv
module lfmbs_cell #(
  parameter int CELL_ID = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lfmbs_pkg::token_t tok_i,
  input  lfmbs_pkg::lane_t  lane_i,
  output lfmbs_pkg::token_t tok_o,
  output lfmbs_pkg::lane_t  lane_o
);
  import lfmbs_pkg::*;

  logic [9:0]         lo_r, lo_nxt;
  logic [9:0]         hi_r, hi_nxt;
  logic signed [15:0] peak_r, peak_nxt;
  token_t             tok_r;
  lane_t              lane_r, lane_nxt;

  logic               in_rng;
  logic signed [15:0] upd;
  logic signed [15:0] fin;

  always_comb begin
    in_rng = tok_i.is_bin && ({1'b0, lo_r} <= tok_i.idx) && (tok_i.idx <= {1'b0, hi_r});
    upd    = (in_rng && (tok_i.value > peak_r)) ? tok_i.value : peak_r;
    fin    = (upd > tok_i.floor) ? upd : tok_i.floor;

    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    peak_nxt = upd;
    lane_nxt = lane_i;
    if (tok_i.is_range && (int'(tok_i.row) == CELL_ID)) begin
      lo_nxt = tok_i.lo;
      hi_nxt = tok_i.hi;
    end
    // Column end: hand the final maximum to the drain lane and restart.
    if (tok_i.is_bin && tok_i.last) begin
      peak_nxt       = tok_i.floor;
      lane_nxt.valid = tok_i.commit;
      lane_nxt.value = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r           <= '0;
      hi_r           <= '0;
      peak_r         <= FLOOR_RST;
      tok_r.is_range <= 1'b0;
      tok_r.is_bin   <= 1'b0;
      lane_r.valid   <= 1'b0;
    end else begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      peak_r <= peak_nxt;
      tok_r  <= tok_i;
      lane_r <= lane_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign lane_o = lane_r;

endmodule

### design/lfmbs_history.sv
module lfmbs_history #(
  parameter int ROWS = 128,
  parameter int COLS = 256
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_row,
  input  logic [$clog2(COLS)-1:0]             wr_slot,
  input  logic signed [15:0]                  wr_data,
  input  logic                                rd_en,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_row,
  input  logic [$clog2(COLS)-1:0]             rd_slot,
  output logic signed [15:0]                  rd_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  logic signed [15:0] mem [DEPTH];
  logic [AW-1:0]      wa;
  logic [AW-1:0]      ra;

  // Row-major: row r occupies COLS consecutive slots.
  assign wa = AW'(int'(wr_row) * COLS + int'(wr_slot));
  assign ra = AW'(int'(rd_row) * COLS + int'(rd_slot));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[ra];
    end
  end

endmodule

### design/log_frequency_max_binning_scroll.sv
// Log-frequency spectrogram with max binning and a scrolling history. Each
// item is one command: set a row's bin range, push one magnitude bin (signed
// Q8.8 dB), read one stored cell, or clear the history. Commands run down a
// chain of ROWS cells, one cell per cycle, so range writes and bins are taken
// one per cycle when no hold-off is active and the result register is free. A
// column end with the expected bin count is reported at once (kind 1) and then
// holds off new items while the row maxima drain along the chain into the
// single write port of the ROWS x COLS history memory; a column of the wrong
// size is reported as kind 2 without a hold-off. A cell read passes an address
// register, a memory read and a result register and holds off new items until
// its result is registered. The history needs no clearing pass: a fill count
// decides which slots hold data and every other cell reads the floor. cfg
// writes are always taken and must only be issued while the block is idle.
`include "log_frequency_max_binning_scroll_macros.svh"

module log_frequency_max_binning_scroll #(
  parameter int ROWS     = 128,
  parameter int COLS     = 256,
  parameter int MAX_BINS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [6:0]         in_row,
  input  logic [9:0]         in_bin_low,
  input  logic [9:0]         in_bin_high,
  input  logic signed [15:0] in_bin_value,
  input  logic               in_bin_last,
  input  logic [7:0]         in_column,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_cell_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lfmbs_pkg::*;

  localparam int RW        = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int CW        = $clog2(COLS);
  localparam int FW        = $clog2(COLS + 1);
  localparam int SUMW      = (CW > 8 ? CW : 8) + 1;
  localparam int STALL_LEN = 2 * ROWS + 1;
  localparam int STW       = $clog2(STALL_LEN + 1);
  localparam int MBM       = MAX_BINS - 1;

  logic signed [15:0] floor_r;
  logic [10:0]        bins_r;
  logic [10:0]        bin_cnt_r;
  logic [CW-1:0]      wp_r;
  logic [FW-1:0]      filled_r;
  logic [STW-1:0]     stall_r;
  logic [CW-1:0]      cslot_r;
  logic [RW-1:0]      wrow_r;
  token_t             tok0_r, tok0_nxt;

  logic               rd1_v_r, rd1_hit_r;
  logic [RW-1:0]      rd1_row_r;
  logic [CW-1:0]      rd1_slot_r;
  logic               rd2_v_r, rd2_hit_r;
  logic signed [15:0] rd_data;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic signed [15:0] out_cell_r;

  token_t             tok  [ROWS+1];
  lane_t              lane [ROWS+1];

  logic               acc;
  logic               out_free;
  logic               out_set;
  logic               commit;
  logic [10:0]        maxb;
  logic [12:0]        maxb_w;
  logic [9:0]         lo_c, hi_c;
  logic [SUMW-1:0]    sum;
  logic               rd_hit;
  logic               rd_load;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (stall_r == '0) && !rd1_v_r && !rd2_v_r && out_free;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign commit    = (bin_cnt_r != CNT_SAT) && (({1'b0, bin_cnt_r} + 12'd1) == {1'b0, bins_r});
  assign rd_load   = rd2_v_r && out_free;
  assign out_set   = rd_load || (acc && (in_opcode == OP_PUSH_BIN) && in_bin_last);

  // Clamp the range to the column size before it enters the chain.
  always_comb begin
    maxb   = (bins_r == '0) ? '0 : bins_r - 11'd1;
    maxb_w = {2'b00, maxb};
    if (maxb_w > 13'(MBM)) begin
      maxb_w = 13'(MBM);
    end
    lo_c = ({3'b000, in_bin_low} > maxb_w) ? maxb_w[9:0] : in_bin_low;
    hi_c = ({3'b000, in_bin_high} > maxb_w) ? maxb_w[9:0] : in_bin_high;
    if (hi_c < lo_c) begin
      hi_c = lo_c;
    end
  end

  // Oldest-first column index onto the circular slot.
  always_comb begin
    sum = SUMW'(wp_r) + SUMW'(in_column);
    if (sum >= SUMW'(COLS)) begin
      sum = sum - SUMW'(COLS);
    end
    rd_hit = (int'(in_column) < COLS) && (int'(in_column) >= COLS - int'(filled_r))
           && (int'(in_row) < ROWS);
  end

  always_comb begin
    tok0_nxt          = '0;
    tok0_nxt.row      = in_row;
    tok0_nxt.lo       = lo_c;
    tok0_nxt.hi       = hi_c;
    tok0_nxt.idx      = bin_cnt_r;
    tok0_nxt.value    = in_bin_value;
    tok0_nxt.floor    = floor_r;
    tok0_nxt.last     = in_bin_last;
    tok0_nxt.commit   = commit;
    if (acc) begin
      case (in_opcode)
        OP_SET_RANGE: tok0_nxt.is_range = 1'b1;
        OP_PUSH_BIN:  tok0_nxt.is_bin   = 1'b1;
        default:      tok0_nxt.is_bin   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r         <= FLOOR_RST;
      bins_r          <= BINS_RST;
      bin_cnt_r       <= '0;
      wp_r            <= '0;
      filled_r        <= '0;
      stall_r         <= '0;
      wrow_r          <= '0;
      tok0_r.is_range <= 1'b0;
      tok0_r.is_bin   <= 1'b0;
      rd1_v_r         <= 1'b0;
      rd2_v_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      tok0_r <= tok0_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_FLOOR: floor_r <= cfg_data;
          CFG_BINS:  bins_r  <= cfg_data[10:0];
          default:   floor_r <= floor_r;
        endcase
      end

      if (stall_r != '0) begin
        stall_r <= stall_r - 1'b1;
      end
      // Drained maxima reach the write port in row order.
      if (lane[0].valid) begin
        wrow_r <= wrow_r + 1'b1;
      end

      // Drop the taken result unless a new one loads at this edge.
      if (out_valid_r && out_ready && !out_set) begin
        out_valid_r <= 1'b0;
      end

      if (rd1_v_r) begin
        rd1_v_r   <= 1'b0;
        rd2_v_r   <= 1'b1;
        rd2_hit_r <= rd1_hit_r;
      end
      if (rd_load) begin
        rd2_v_r     <= 1'b0;
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_CELL;
        out_cell_r  <= rd2_hit_r ? rd_data : floor_r;
      end

      if (acc) begin
        case (in_opcode)
          OP_PUSH_BIN: begin
            if (in_bin_last) begin
              bin_cnt_r   <= '0;
              out_valid_r <= 1'b1;
              out_cell_r  <= '0;
              if (commit) begin
                out_kind_r <= KIND_ACCEPT;
                cslot_r    <= wp_r;
                wrow_r     <= '0;
                stall_r    <= STW'(STALL_LEN);
                wp_r       <= (wp_r == CW'(COLS - 1)) ? '0 : wp_r + 1'b1;
                if (filled_r != FW'(COLS)) begin
                  filled_r <= filled_r + 1'b1;
                end
              end else begin
                out_kind_r <= KIND_DROP;
              end
            end else if (bin_cnt_r != CNT_SAT) begin
              bin_cnt_r <= bin_cnt_r + 11'd1;
            end
          end
          OP_READ_CELL: begin
            rd1_v_r    <= 1'b1;
            rd1_hit_r  <= rd_hit;
            rd1_row_r  <= RW'(in_row);
            rd1_slot_r <= sum[CW-1:0];
          end
          OP_CLEAR: begin
            filled_r <= '0;
            wp_r     <= '0;
          end
          default: begin
            bin_cnt_r <= bin_cnt_r;
          end
        endcase
      end
    end
  end

  assign tok[0]     = tok0_r;
  assign lane[ROWS] = '0;

  for (genvar g = 0; g < ROWS; g++) begin : g_cell
    lfmbs_cell #(
      .CELL_ID(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok[g]),
      .lane_i (lane[g+1]),
      .tok_o  (tok[g+1]),
      .lane_o (lane[g])
    );
  end

  lfmbs_history #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_history (
    .clk     (clk),
    .wr_en   (lane[0].valid),
    .wr_row  (wrow_r),
    .wr_slot (cslot_r),
    .wr_data (lane[0].value),
    .rd_en   (rd1_v_r),
    .rd_row  (rd1_row_r),
    .rd_slot (rd1_slot_r),
    .rd_data (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_cell_value = out_cell_r;

  // History writes only happen inside the hold-off window of a commit.
  `LFMBS_ASSERT_IMP(a_wr_in_window, lane[0].valid, stall_r != '0)
  // A committing column end still in the chain keeps new items out.
  `LFMBS_ASSERT_IMP(a_tail_in_window, tok[ROWS].is_bin && tok[ROWS].last && tok[ROWS].commit, stall_r != '0)
  // A commit restarts the drain row count and opens the window.
  `LFMBS_ASSERT_NXT(a_commit_start, acc && (in_opcode == OP_PUSH_BIN) && in_bin_last && commit, (wrow_r == '0) && (stall_r != '0))
  // Reads never overlap history writes.
  `LFMBS_ASSERT_IMP(a_rd_no_wr, rd1_v_r, !lane[0].valid)

endmodule

### test/tb_log_frequency_max_binning_scroll.sv
`timescale 1ns / 1ps

module tb_log_frequency_max_binning_scroll;
  import lfmbs_pkg::*;

  localparam int ROWS          = 128;
  localparam int COLS          = 256;
  localparam int MAX_BINS      = 1024;
  localparam int SETTLE_CYCLES = 3 * ROWS + 32;
  localparam int CYCLE_LIMIT   = 1500000;

  typedef struct {
    logic [1:0]         opcode;
    logic [6:0]         row;
    logic [9:0]         lo;
    logic [9:0]         hi;
    logic signed [15:0] value;
    logic               last;
    logic [7:0]         column;
  } cmd_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] cell_value;
  } report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = OP_READ_CELL;
  logic [6:0]         in_row = '0;
  logic [9:0]         in_bin_low = '0;
  logic [9:0]         in_bin_high = '0;
  logic signed [15:0] in_bin_value = '0;
  logic               in_bin_last = 1'b0;
  logic [7:0]         in_column = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic signed [15:0] out_cell_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_FLOOR;
  logic [15:0]        cfg_data = '0;

  log_frequency_max_binning_scroll #(
    .ROWS(ROWS),
    .COLS(COLS),
    .MAX_BINS(MAX_BINS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_row(in_row),
    .in_bin_low(in_bin_low),
    .in_bin_high(in_bin_high),
    .in_bin_value(in_bin_value),
    .in_bin_last(in_bin_last),
    .in_column(in_column),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_cell_value(out_cell_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted block state
  logic signed [15:0] floor_q;
  logic [10:0]        bin_count_q;
  logic [9:0]         range_lo [ROWS];
  logic [9:0]         range_hi [ROWS];
  logic signed [15:0] row_peak [ROWS];
  logic [10:0]        bin_idx;
  logic signed [15:0] history [ROWS][COLS];
  logic [7:0]         wr_ptr;
  int                 filled;

  report_t pending_reports[$];

  int mismatch_count = 0;
  int items_taken = 0;
  int reads_sent = 0;
  int columns_stored = 0;
  int columns_dropped = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  int burst_left = 0;
  int gap_max = 0;
  int stall_max = 0;
  int hold_request = 0;
  int hold_left = 0;
  int run_left = 0;
  bit rx_open = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic bin_and_scroll(input cmd_t c);
    report_t r;
    int top;
    int lo;
    int hi;
    logic [7:0] slot;
    case (c.opcode)
      OP_SET_RANGE: begin
        top = (bin_count_q == 0) ? 0 : int'(bin_count_q) - 1;
        if (top > MAX_BINS - 1) top = MAX_BINS - 1;
        lo = (int'(c.lo) > top) ? top : int'(c.lo);
        hi = (int'(c.hi) > top) ? top : int'(c.hi);
        if (hi < lo) hi = lo;
        range_lo[c.row] = 10'(lo);
        range_hi[c.row] = 10'(hi);
      end
      OP_PUSH_BIN: begin
        for (int i = 0; i < ROWS; i++)
          if (bin_idx >= range_lo[i] && bin_idx <= range_hi[i] && c.value > row_peak[i])
            row_peak[i] = c.value;
        if (!c.last) begin
          if (bin_idx < CNT_SAT) bin_idx++;
        end else begin
          r.cell_value = '0;
          if (bin_idx < CNT_SAT && bin_idx + 11'd1 == bin_count_q) begin
            for (int i = 0; i < ROWS; i++)
              history[i][wr_ptr] = (row_peak[i] > floor_q) ? row_peak[i] : floor_q;
            wr_ptr++;
            if (filled < COLS) filled++;
            r.kind = KIND_ACCEPT;
            columns_stored++;
          end else begin
            r.kind = KIND_DROP;
            columns_dropped++;
          end
          pending_reports.push_back(r);
          for (int i = 0; i < ROWS; i++) row_peak[i] = floor_q;
          bin_idx = '0;
        end
      end
      OP_READ_CELL: begin
        r.kind = KIND_CELL;
        r.cell_value = floor_q;
        if (int'(c.column) >= COLS - filled) begin
          slot = wr_ptr + c.column;
          r.cell_value = history[c.row][slot];
        end
        pending_reports.push_back(r);
        reads_sent++;
      end
      default: begin
        filled = 0;
        wr_ptr = '0;
      end
    endcase
  endtask

  // Track writes and items, then check results in the same edge
  always @(posedge clk) begin : monitor
    cmd_t c;
    report_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == CFG_FLOOR) floor_q = cfg_data;
        else if (cfg_index == CFG_BINS) bin_count_q = cfg_data[10:0];
      end
      if (in_valid && in_ready) begin
        c.opcode = in_opcode;
        c.row    = in_row;
        c.lo     = in_bin_low;
        c.hi     = in_bin_high;
        c.value  = in_bin_value;
        c.last   = in_bin_last;
        c.column = in_column;
        items_taken++;
        bin_and_scroll(c);
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("result with nothing pending, kind", int'(out_kind), 0);
        end else begin
          want = pending_reports.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", int'(out_kind), int'(want.kind));
          if (out_cell_value !== want.cell_value)
            report_mismatch("cell_value", int'(out_cell_value), int'(want.cell_value));
        end
      end
    end
  end

  // Receiver: alternate ready and stall runs, or hold off on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        rx_open = (stall_max == 0) || !rx_open;
        run_left = rx_open ? $urandom_range(1, 24) : $urandom_range(1, stall_max);
      end
      run_left--;
      out_ready <= rx_open;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out with %0d results still pending", pending_reports.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_opcode    <= c.opcode;
    in_row       <= c.row;
    in_bin_low   <= c.lo;
    in_bin_high  <= c.hi;
    in_bin_value <= c.value;
    in_bin_last  <= c.last;
    in_column    <= c.column;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic cmd_t random_cmd(input logic [1:0] op);
    cmd_t c;
    c.opcode = op;
    c.row    = 7'($urandom);
    c.lo     = 10'($urandom);
    c.hi     = 10'($urandom);
    c.value  = 16'($urandom);
    c.last   = 1'($urandom);
    c.column = 8'($urandom);
    return c;
  endfunction

  task automatic set_range(input logic [6:0] row, input logic [9:0] lo, input logic [9:0] hi);
    cmd_t c;
    c = random_cmd(OP_SET_RANGE);
    c.row = row;
    c.lo  = lo;
    c.hi  = hi;
    send_item(c);
  endtask

  task automatic push_bin(input logic signed [15:0] value, input logic last);
    cmd_t c;
    c = random_cmd(OP_PUSH_BIN);
    c.value = value;
    c.last  = last;
    send_item(c);
  endtask

  task automatic read_cell(input logic [6:0] row, input logic [7:0] column);
    cmd_t c;
    c = random_cmd(OP_READ_CELL);
    c.row    = row;
    c.column = column;
    send_item(c);
  endtask

  task automatic clear_store();
    send_item(random_cmd(OP_CLEAR));
  endtask

  // Sometimes near the floor so that the floor clamp at commit matters
  function automatic logic signed [15:0] random_level();
    if ($urandom_range(0, 3) == 0)
      return floor_q + 16'($urandom_range(0, 511)) - 16'sd256;
    return 16'($urandom);
  endfunction

  task automatic push_column(input int n);
    for (int i = 0; i < n; i++) push_bin(random_level(), i == n - 1);
  endtask

  task automatic random_range();
    int span;
    span = (int'(bin_count_q) + 2 > MAX_BINS - 1) ? MAX_BINS - 1 : int'(bin_count_q) + 2;
    if ($urandom_range(0, 1))
      set_range(7'($urandom), 10'($urandom_range(0, span)), 10'($urandom_range(0, span)));
    else
      set_range(7'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic read_random();
    if (filled > 0 && $urandom_range(0, 3) != 0)
      read_cell(7'($urandom), 8'($urandom_range(COLS - filled, COLS - 1)));
    else
      read_cell(7'($urandom), 8'($urandom));
  endtask

  // Registers change only with the block drained of both results and work
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic signed [15:0] level, input logic [10:0] count);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FLOOR;
    cfg_data  <= level;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_BINS;
    cfg_data  <= {5'd0, count};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    gap_max = 2;
    stall_max = 3;
    // empty store and a short column under reset settings
    read_cell(7'd0, 8'd255);
    push_bin(16'sd100, 1'b1);
    configure(-16'sd2560, 11'd4);
    set_range(7'd0, 10'd0, 10'd1023);
    set_range(7'd127, 10'd1023, 10'd0);
    set_range(7'd5, 10'd2, 10'd1);
    push_bin(-16'sd32768, 1'b0);
    push_bin(16'sd32767, 1'b0);
    push_bin(16'sd256, 1'b0);
    push_bin(-16'sd1, 1'b1);
    read_cell(7'd0, 8'd255);
    read_cell(7'd127, 8'd255);
    read_cell(7'd5, 8'd255);
    read_cell(7'd1, 8'd255);
    read_cell(7'd0, 8'd0);
    read_cell(7'd0, 8'd254);
    clear_store();
    read_cell(7'd0, 8'd255);
    // clear in the middle of a column keeps the column
    push_bin(16'sd100, 1'b0);
    push_bin(16'sd200, 1'b0);
    clear_store();
    push_bin(16'sd300, 1'b0);
    push_bin(16'sd400, 1'b1);
    read_cell(7'd0, 8'd255);
  endtask

  task automatic test_column_sizes();
    int n;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      configure(16'($urandom), 11'($urandom_range(2, 12)));
      gap_max = 2 * phase;
      stall_max = 3 * (3 - phase);
      for (int k = 0; k < 10; k++) random_range();
      for (int col = 0; col < 12; col++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_item(random_cmd(2'($urandom)));
        else if (pick < 12) clear_store();
        else if (pick < 20) random_range();
        n = int'(bin_count_q);
        if (pick >= 85) begin
          n = $urandom_range(1, int'(bin_count_q) + 3);
          if (n == int'(bin_count_q)) n = n + 1;
        end
        push_column(n);
        repeat ($urandom_range(1, 3)) read_random();
      end
    end
  endtask

  task automatic test_scroll_wrap();
    configure(-16'sd32768, 11'd1);
    gap_max = 0;
    stall_max = 0;
    for (int k = 0; k < 6; k++) random_range();
    for (int k = 0; k < 300; k++) begin
      // a two-bin column is the wrong size here
      if (k % 25 == 24) push_bin(random_level(), 1'b0);
      push_bin(random_level(), 1'b1);
      if (k % 4 == 3) read_random();
    end
    gap_max = 5;
    stall_max = 8;
    read_cell(7'd127, 8'd0);
    read_cell(7'd0, 8'd255);
    repeat (40) read_random();
    clear_store();
    push_column(1);
    push_column(1);
    read_cell(7'd3, 8'd254);
    read_cell(7'd3, 8'd253);
  endtask

  task automatic test_wide_column();
    configure(16'($urandom), 11'd300);
    gap_max = 3;
    stall_max = 5;
    set_range(7'd0, 10'd0, 10'd1023);
    set_range(7'd127, 10'd1023, 10'd1023);
    for (int k = 0; k < 14; k++) random_range();
    push_column(300);
    read_cell(7'd0, 8'd255);
    read_cell(7'd127, 8'd255);
    repeat (20) read_random();
    push_column(5);
    read_random();
  endtask

  task automatic test_floor_ceiling();
    configure(16'sh7FFF, 11'd3);
    for (int k = 0; k < 4; k++) random_range();
    push_column(3);
    push_column(2);
    push_column(3);
    repeat (4) read_random();
  endtask

  task automatic test_back_pressure();
    configure(16'($urandom), 11'd2);
    gap_max = 0;
    stall_max = 0;
    for (int k = 0; k < 4; k++) random_range();
    hold_request = 300;
    for (int k = 0; k < 30; k++) begin
      if (k % 3 == 2) push_column(2);
      else read_random();
    end
  endtask

  initial begin
    floor_q = FLOOR_RST;
    bin_count_q = BINS_RST;
    bin_idx = '0;
    wr_ptr = '0;
    filled = 0;
    for (int i = 0; i < ROWS; i++) begin
      range_lo[i] = '0;
      range_hi[i] = '0;
      row_peak[i] = FLOOR_RST;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_column_sizes();
    test_scroll_wrap();
    test_wide_column();
    test_floor_ceiling();
    test_back_pressure();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d items, %0d cell reads, %0d columns stored, %0d dropped",
             items_taken, reads_sent, columns_stored, columns_dropped);
    $display("Register writes: %0d, including floor extremes and one-bin columns", cfg_writes);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
